// ----- src/box_nms_hard_or_blend_defines.svh -----
// Assertion macros shared by the box NMS RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef BOX_NMS_HARD_OR_BLEND_DEFINES_SVH
`define BOX_NMS_HARD_OR_BLEND_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define BNMS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define BNMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BNMS_ASSERT(lbl, clk, rst, prop, msg)
`define BNMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/bnms_pkg.sv -----
// Shared types, sizes and the exp weight lookup for the box NMS block.
// Used by every module of the block; depends on nothing.
package bnms_pkg;

  localparam int MAX_BOXES      = 64;
  localparam int EXP_TABLE_BITS = 8;
  localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;
  localparam int PIPE_DEPTH     = 4;
  localparam int RING_LEN       = MAX_BOXES + PIPE_DEPTH;
  localparam int RING_W         = $clog2(RING_LEN);
  localparam int CNT_W          = $clog2(MAX_BOXES + 1);
  localparam int TOT_W          = $clog2(MAX_BOXES) + 16;
  localparam int ACC_W          = TOT_W + 16;
  localparam int NFLD           = 5;
  localparam int FLD_W          = 3;
  localparam int QUOT_W         = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_IOU_LIMIT  = 2'd0;
  localparam logic [1:0] REG_BLEND_MODE = 2'd1;
  localparam logic [15:0] IOU_RESET     = 16'd32768;

  typedef struct packed {
    logic [15:0] y2;
    logic [15:0] x2;
    logic [15:0] y1;
    logic [15:0] x1;
  } box_t;

  typedef struct packed {
    logic        done;
    logic [15:0] score;
    box_t        box;
  } body_t;

  typedef struct packed {
    logic  valid;
    body_t body;
  } item_t;

  typedef struct packed {
    logic load;
    logic rotate;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic                  take;
    logic                  merged;
    logic [15:0]           w;
    logic [NFLD-1:0][31:0] p;
  } contrib_t;

  typedef enum logic [1:0] {ST_LOAD, ST_SUPP, ST_DIV, ST_EMIT} state_t;

  typedef logic [15:0] exp_lut_t [EXP_SIZE];

  // exp(k / EXP_SIZE) in Q2.14, Taylor series in Q4.28, rounded to nearest
  function automatic exp_lut_t build_exp();
    exp_lut_t    lut;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k < EXP_SIZE; k++) begin
      x    = (64'(k) << 28) >> EXP_TABLE_BITS;
      term = 64'd1 << 28;
      sum  = 64'd0;
      for (int n = 1; n <= 24; n++) begin
        sum  = sum + term;
        term = ((term * x) >> 28) / 64'(n);
      end
      lut[k] = 16'((sum + (64'd1 << 13)) >> 14);
    end
    return lut;
  endfunction

  localparam exp_lut_t EXP_LUT = build_exp();

endpackage

// ----- src/box_nms_hard_or_blend.sv -----
// Top level of the box NMS block: load ring, suppression control, output.
// Depends on bnms_pkg, bnms_cell, bnms_merge, bnms_div and the defines header.
//
// Boxes stream in one per cycle and are insertion-sorted by score on arrival
// into a ring of MAX_BOXES cells (equal scores keep arrival order); boxes past
// capacity are dropped and every result of that set carries overflowed. The
// item with tlast closes the set. Suppression then rotates the whole ring,
// MAX_BOXES cells plus the four-stage IoU pipeline, once per group: the first
// unmerged box met leads the group and every later box is tested against it.
// Each group costs one pass of the ring; in blend mode five divisions follow,
// then the result waits for m_tready. No new box is taken until the last
// result of a set is out.
`include "box_nms_hard_or_blend_defines.svh"
module box_nms_hard_or_blend import bnms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // box_x1, box_y1, box_x2, box_y2, box_score
  input  logic        s_tlast,   // set_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // out_x1, out_y1, out_x2, out_y2, out_score
  output logic        m_tlast,   // out_last
  output logic        m_tuser,   // overflowed
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t             state, state_next;
  logic [15:0]        iou_limit;
  logic               blend_mode;
  logic [CNT_W-1:0]   count;
  logic               drop;
  logic [CNT_W-1:0]   left;
  logic [CNT_W-1:0]   left_next;
  logic [RING_W-1:0]  rot_cnt;
  logic               have_lead;
  box_t               lead_box;
  logic [15:0]        lead_score;
  logic [ACC_W-1:0]   acc [NFLD];
  logic [TOT_W-1:0]   tot;
  logic [FLD_W-1:0]   fld;
  logic               div_go;
  logic               div_done;
  logic [QUOT_W-1:0]  quot;
  logic [15:0]        res [NFLD];
  logic               res_last;
  logic               res_ovf;

  logic               in_acc;
  logic               full;
  logic               pass_end;
  logic               is_lead;
  logic               is_comp;
  item_t              ins_item;
  item_t              head;
  item_t              pipe_in;
  item_t              pipe_out;
  contrib_t           contrib;
  cell_ctl_t          ctl;
  item_t              cell_q [MAX_BOXES];
  logic               cell_gt [MAX_BOXES];

  // Handshake and control decode
  always_comb begin
    s_tready = (state == ST_LOAD);
    m_tvalid = (state == ST_EMIT);
  end

  assign in_acc   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(MAX_BOXES));
  assign ins_item = '{valid: 1'b1,
                      body: '{done: 1'b0, score: s_tdata[79:64], box: s_tdata[63:0]}};
  assign ctl      = '{load:   in_acc && !full,
                      rotate: state == ST_SUPP,
                      clear:  m_tvalid && m_tready && res_last};

  assign head     = cell_q[0];
  assign is_lead  = ctl.rotate && head.valid && !head.body.done && !have_lead;
  assign is_comp  = ctl.rotate && head.valid && !head.body.done && have_lead;
  assign pass_end = (state == ST_SUPP) && (rot_cnt == RING_W'(RING_LEN - 1));

  always_comb begin
    pipe_in           = head;
    pipe_in.body.done = head.body.done | is_lead;
  end

  assign left_next = left - CNT_W'(is_lead) - CNT_W'(contrib.merged);

  // Ring of cells, head at index 0, pipeline exit feeds the tail
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_ring
    item_t up_item;
    item_t down_item;
    logic  up_gt;
    if (i == 0) begin : g_head
      assign up_item = '0;
      assign up_gt   = 1'b0;
    end else begin : g_body
      assign up_item = cell_q[i-1];
      assign up_gt   = cell_gt[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_tail
      assign down_item = pipe_out;
    end else begin : g_mid
      assign down_item = cell_q[i+1];
    end
    bnms_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .ins  (ins_item),
      .up   (up_item),
      .up_gt(up_gt),
      .down (down_item),
      .cur  (cell_q[i]),
      .gt   (cell_gt[i])
    );
  end

  bnms_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (ctl.rotate),
    .iou_limit(iou_limit),
    .lead     (lead_box),
    .in_item  (pipe_in),
    .in_lead  (is_lead),
    .in_comp  (is_comp),
    .out_item (pipe_out),
    .contrib  (contrib)
  );

  bnms_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_go),
    .dividend(acc[fld]),
    .divisor (tot),
    .done    (div_done),
    .quot    (quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_acc && s_tlast) state_next = ST_SUPP;
      ST_SUPP: if (pass_end) state_next = blend_mode ? ST_DIV : ST_EMIT;
      ST_DIV:  if (div_done && fld == FLD_W'(NFLD - 1)) state_next = ST_EMIT;
      ST_EMIT: if (m_tready) state_next = res_last ? ST_LOAD : ST_SUPP;
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_limit  <= IOU_RESET;
      blend_mode <= 1'b0;
      count      <= '0;
      drop       <= 1'b0;
      left       <= '0;
      rot_cnt    <= '0;
      have_lead  <= 1'b0;
      div_go     <= 1'b0;
      fld        <= '0;
    end else begin
      div_go <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IOU_LIMIT:  iou_limit  <= cfg_data;
          REG_BLEND_MODE: blend_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
        if (s_tlast) begin
          left <= full ? count : count + CNT_W'(1);
        end
      end
      if (state == ST_SUPP) begin
        rot_cnt   <= rot_cnt + RING_W'(1);
        have_lead <= have_lead | is_lead;
        left      <= left_next;
        if (pass_end) begin
          rot_cnt   <= '0;
          have_lead <= 1'b0;
          fld       <= '0;
          div_go    <= blend_mode;
        end
      end
      if (state == ST_DIV && div_done) begin
        fld <= fld + FLD_W'(1);
        if (fld != FLD_W'(NFLD - 1)) begin
          div_go <= 1'b1;
        end
      end
      if (ctl.clear) begin
        count <= '0;
        drop  <= 1'b0;
      end
    end
  end

  // Leader, group sums and result fields
  always_ff @(posedge clk) begin
    if (is_lead) begin
      lead_box   <= head.body.box;
      lead_score <= head.body.score;
    end
    if (state == ST_SUPP) begin
      if (contrib.take) begin
        for (int k = 0; k < NFLD; k++) begin
          acc[k] <= acc[k] + ACC_W'(contrib.p[k]);
        end
        tot <= tot + TOT_W'(contrib.w);
      end
    end else if (state != ST_DIV) begin
      for (int k = 0; k < NFLD; k++) begin
        acc[k] <= '0;
      end
      tot <= '0;
    end
    if (pass_end) begin
      res_last <= (left_next == '0);
      res_ovf  <= drop;
      if (!blend_mode) begin
        res[0] <= lead_box.x1;
        res[1] <= lead_box.y1;
        res[2] <= lead_box.x2;
        res[3] <= lead_box.y2;
        res[4] <= lead_score;
      end
    end
    if (state == ST_DIV && div_done) begin
      res[fld] <= quot;
    end
  end

  assign m_tdata = {res[4], res[3], res[2], res[1], res[0]};
  assign m_tlast = res_last;
  assign m_tuser = res_ovf;

  `BNMS_ASSERT(a_pass_has_leader, clk, rst,
    (state == ST_SUPP && rot_cnt == '0) |-> (left != '0), "pass started with no box left")
  `BNMS_ASSERT_NEXT(a_set_cleared, clk, rst,
    (m_tvalid && m_tready && m_tlast), (count == '0 && !drop), "set not cleared after last")
  `BNMS_ASSERT(a_weight_nonzero, clk, rst,
    (state == ST_DIV) |-> (tot != '0), "blend divide with zero weight sum")

endmodule

// ----- src/bnms_cell.sv -----
// One cell of the box ring: holds one ranked box and its done mark (leader or merged).
// Depends on bnms_pkg for the item and control types.
module bnms_cell import bnms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  item_t     ins,
  input  item_t     up,
  input  logic      up_gt,
  input  item_t     down,
  output item_t     cur,
  output logic      gt
);

  logic  valid;
  logic  valid_next;
  body_t body;
  body_t body_next;
  logic  take_up;
  logic  take_ins;

  // New item outranks this slot when the slot is empty or has a lower score
  assign gt       = !valid || (ins.body.score > body.score);
  assign take_up  = ctl.load && gt && up_gt;
  assign take_ins = ctl.load && gt && !up_gt;

  // Pick the next content: clear, shift down on insert, or rotate toward the head
  always_comb begin
    valid_next = valid;
    body_next  = body;
    if (ctl.clear) begin
      valid_next = 1'b0;
    end else if (ctl.rotate) begin
      valid_next = down.valid;
      body_next  = down.body;
    end else if (take_up) begin
      valid_next = up.valid;
      body_next  = up.body;
    end else if (take_ins) begin
      valid_next = 1'b1;
      body_next  = ins.body;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    body <= body_next;
  end

  assign cur = '{valid: valid, body: body};

endmodule

// ----- src/bnms_merge.sv -----
// Four-stage IoU test and weight product stages spliced into the box ring.
// Depends on bnms_pkg for item types and the exp weight lookup.
module bnms_merge import bnms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [15:0] iou_limit,
  input  box_t        lead,
  input  item_t       in_item,
  input  logic        in_lead,
  input  logic        in_comp,
  output item_t       out_item,
  output contrib_t    contrib
);

  typedef struct packed {
    logic valid;
    logic lead;
    logic comp;
  } flag_t;

  flag_t                 f1, f2, f3, f4;
  body_t                 b1, b2, b3, b4;
  logic signed [17:0]    iw1, ih1, wb1, hb1;
  logic [15:0]           w1, w2, w3, w4;
  logic signed [35:0]    inter2, a2, inter3;
  logic                  pos2, pos3, ok4;
  logic signed [36:0]    uni3;
  logic [NFLD-1:0][31:0] p3, p4;
  logic [35:0]           inter4;
  logic [33:0]           pl4, ph4;
  logic signed [35:0]    lead_area;
  logic signed [17:0]    lw, lh;
  logic [53:0]           lhs, rhs;
  logic                  merge;
  logic [15:0]           mx1, my1, mx2, my2;

  function automatic logic signed [17:0] sx(input logic [15:0] v);
    return $signed({2'b00, v});
  endfunction

  // Leader extents and area, refreshed every cycle from the leader register
  assign lw = sx(lead.x2) - sx(lead.x1) + 18'sd16;
  assign lh = sx(lead.y2) - sx(lead.y1) + 18'sd16;
  always_ff @(posedge clk) begin
    lead_area <= lw * lh;
  end

  // Intersection corners against the leader
  assign mx1 = (in_item.body.box.x1 > lead.x1) ? in_item.body.box.x1 : lead.x1;
  assign my1 = (in_item.body.box.y1 > lead.y1) ? in_item.body.box.y1 : lead.y1;
  assign mx2 = (in_item.body.box.x2 < lead.x2) ? in_item.body.box.x2 : lead.x2;
  assign my2 = (in_item.body.box.y2 < lead.y2) ? in_item.body.box.y2 : lead.y2;

  // Advance the flag stages
  always_ff @(posedge clk) begin
    if (rst) begin
      f1 <= '0;
      f2 <= '0;
      f3 <= '0;
      f4 <= '0;
    end else if (en) begin
      f1 <= '{valid: in_item.valid, lead: in_lead, comp: in_comp};
      f2 <= f1;
      f3 <= f2;
      f4 <= f3;
    end
  end

  // Advance the data stages: extents, areas, union, threshold products
  always_ff @(posedge clk) begin
    if (en) begin
      b1  <= in_item.body;
      iw1 <= sx(mx2) - sx(mx1) + 18'sd16;
      ih1 <= sx(my2) - sx(my1) + 18'sd16;
      wb1 <= sx(in_item.body.box.x2) - sx(in_item.body.box.x1) + 18'sd16;
      hb1 <= sx(in_item.body.box.y2) - sx(in_item.body.box.y1) + 18'sd16;
      w1  <= EXP_LUT[in_item.body.score[15 -: EXP_TABLE_BITS]];

      b2     <= b1;
      inter2 <= iw1 * ih1;
      a2     <= wb1 * hb1;
      pos2   <= (iw1 > 18'sd0) && (ih1 > 18'sd0);
      w2     <= w1;

      b3     <= b2;
      inter3 <= inter2;
      uni3   <= 37'(lead_area) + 37'(a2) - 37'(inter2);
      pos3   <= pos2;
      w3     <= w2;
      p3[0]  <= b2.box.x1 * w2;
      p3[1]  <= b2.box.y1 * w2;
      p3[2]  <= b2.box.x2 * w2;
      p3[3]  <= b2.box.y2 * w2;
      p3[4]  <= b2.score * w2;

      b4     <= b3;
      inter4 <= inter3[35:0];
      ok4    <= pos3 && (uni3 > 37'sd0);
      pl4    <= iou_limit * uni3[17:0];
      ph4    <= iou_limit * uni3[35:18];
      w4     <= w3;
      p4     <= p3;
    end
  end

  // Merge when inter * 2^16 exceeds iou_limit * union
  assign lhs   = {2'b00, inter4, 16'h0000};
  assign rhs   = ({20'd0, ph4} << 18) + {20'd0, pl4};
  assign merge = f4.valid && f4.comp && ok4 && (lhs > rhs);

  always_comb begin
    out_item            = '{valid: f4.valid, body: b4};
    out_item.body.done  = b4.done | merge;
    contrib.take        = f4.valid && (f4.lead || merge);
    contrib.merged      = merge;
    contrib.w           = w4;
    contrib.p           = p4;
  end

endmodule

// ----- src/bnms_div.sv -----
// Restoring divider for the blended averages, one quotient bit per cycle.
// Depends on bnms_pkg for the accumulator and weight-sum widths.
module bnms_div import bnms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  dividend,
  input  logic [TOT_W-1:0]  divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int DW    = TOT_W + QUOT_W - 1;
  localparam int STEPW = $clog2(QUOT_W);

  logic             busy;
  logic [STEPW-1:0] step;
  logic [ACC_W-1:0] rem;
  logic [DW-1:0]    dsh;
  logic             fits;

  assign fits = rem >= ACC_W'(dsh);

  // Control: run one step per cycle and pulse done after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEPW'(QUOT_W - 1);
      end else if (busy) begin
        step <= step - STEPW'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= DW'(divisor) << (QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - ACC_W'(dsh);
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule
